/* src/bpu_pkg.sv */
// Shared types and constants of the BMP pixel unpacker.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package bpu_pkg;

  localparam int DIM_W     = 13;  // width of the image width/height registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 24;
  localparam int PAL_AW    = 8;
  localparam int PAL_DEPTH = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  typedef enum logic [1:0] {
    DEPTH_1BIT  = 2'd0,
    DEPTH_4BIT  = 2'd1,
    DEPTH_8BIT  = 2'd2,
    DEPTH_24BIT = 2'd3
  } depth_t;

  typedef struct packed {
    depth_t             depth;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [PAL_AW-1:0]   addr;
    logic [COLOR_W-1:0]  data;
  } pal_wr_t;

  // One pixel on its way from the unpacker to the output stage
  typedef struct packed {
    logic                valid;
    logic                use_table;
    logic [PAL_AW-1:0]   addr;
    logic [COLOR_W-1:0]  rgb;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last_of_run;
    logic                last_of_image;
  } pix_desc_t;

endpackage

`default_nettype wire

/* src/bpu_if.sv */
// Valid/ready channel interfaces of the BMP pixel unpacker.
// Depends on bpu_pkg for field widths.
`default_nettype none

interface bpu_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [bpu_pkg::PAL_AW-1:0]    palette_index;
  logic [bpu_pkg::COLOR_W-1:0]   palette_color;
  logic [7:0]                    data_byte;

  modport source (output valid, mode, palette_index, palette_color, data_byte,
                  input ready);
  modport sink   (input valid, mode, palette_index, palette_color, data_byte,
                  output ready);
endinterface

interface bpu_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;
  logic [bpu_pkg::COORD_W-1:0]   pixel_x;
  logic [bpu_pkg::COORD_W-1:0]   pixel_y;
  logic                          last_of_run;
  logic                          last_of_image;

  modport source (output valid, red, green, blue, pixel_x, pixel_y, last_of_run,
                  last_of_image, input ready);
  modport sink   (input valid, red, green, blue, pixel_x, pixel_y, last_of_run,
                  last_of_image, output ready);
endinterface

`default_nettype wire

/* src/bpu_unpack.sv */
// Input register and pixel sequencer: splits each data byte into pixels,
// tracks column/row/padding and issues palette writes and reads.
// Depends on bpu_pkg and bpu_if.
`default_nettype none

module bpu_unpack #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  bpu_in_if.sink                   in_ch,
  input  wire bpu_pkg::cfg_t       cfg,
  input  wire logic                adv,
  output bpu_pkg::pal_wr_t         pal_wr,
  output bpu_pkg::pix_desc_t       desc
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = (bpu_pkg::DIM_W > XW + 1) ? bpu_pkg::DIM_W : XW + 1;
  localparam int HW = (bpu_pkg::DIM_W > YW + 1) ? bpu_pkg::DIM_W : YW + 1;

  // input register
  logic                           in_valid_r;
  logic                           mode_r;
  logic [bpu_pkg::PAL_AW-1:0]     pidx_r;
  logic [bpu_pkg::COLOR_W-1:0]    pcol_r;
  logic [7:0]                     byte_r;

  // position state
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [7:0]    held_blue_r, held_blue_nxt;
  logic [7:0]    held_green_r, held_green_nxt;
  logic [1:0]    triple_r, triple_nxt;
  logic [2:0]    sub_r, sub_nxt;

  logic [WW-1:0] w_lim, w_m1;
  logic [HW-1:0] h_lim, h_m1;
  logic          first;
  logic [XW-1:0] col_cur;
  logic [YW-1:0] row_cur;
  logic [1:0]    phase_cur;
  logic          row_end;
  logic          row_last;
  logic          emit;
  logic          last_pix;
  logic          consume;
  logic          in_acc;

  always_comb begin
    if (cfg.width == '0) begin
      w_lim = WW'(1);
    end else if (WW'(cfg.width) > WW'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_lim = HW'(1);
    end else if (HW'(cfg.height) > HW'(MAX_HEIGHT)) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(cfg.height);
    end
    w_m1 = w_lim - WW'(1);
    h_m1 = h_lim - HW'(1);
  end

  // Clamp the position and count the byte only on its first pixel
  assign first     = (sub_r == 3'd0);
  assign col_cur   = (first && WW'(col_r) >= w_lim) ? '0 : col_r;
  assign row_cur   = (first && HW'(row_r) >= h_lim) ? '0 : row_r;
  assign phase_cur = first ? phase_r + 2'd1 : phase_r;
  assign row_end   = (WW'(col_cur) == w_m1);
  assign row_last  = (HW'(row_cur) == h_m1);
  assign emit      = (cfg.depth != bpu_pkg::DEPTH_24BIT) || triple_r[1];

  always_comb begin
    case (cfg.depth)
      bpu_pkg::DEPTH_1BIT: last_pix = row_end || (sub_r == 3'd7);
      bpu_pkg::DEPTH_4BIT: last_pix = row_end || sub_r[0];
      default:             last_pix = 1'b1;
    endcase
  end

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    phase_nxt      = phase_r;
    pad_nxt        = pad_r;
    held_blue_nxt  = held_blue_r;
    held_green_nxt = held_green_r;
    triple_nxt     = triple_r;
    sub_nxt        = sub_r;
    consume        = 1'b0;
    pal_wr         = '0;
    desc           = '0;

    desc.x             = bpu_pkg::COORD_W'(col_cur);
    desc.y             = bpu_pkg::COORD_W'(h_m1 - HW'(row_cur));
    desc.last_of_run   = last_pix;
    desc.last_of_image = row_end && row_last;
    desc.rgb           = {byte_r, held_green_r, held_blue_r};
    case (cfg.depth)
      bpu_pkg::DEPTH_1BIT: desc.addr = {7'd0, byte_r[~sub_r]};
      bpu_pkg::DEPTH_4BIT: desc.addr = sub_r[0] ? {4'd0, byte_r[3:0]}
                                                : {4'd0, byte_r[7:4]};
      default:             desc.addr = byte_r;
    endcase
    desc.use_table = (cfg.depth != bpu_pkg::DEPTH_24BIT);

    if (in_valid_r) begin
      if (mode_r == bpu_pkg::MODE_PALETTE) begin
        pal_wr.we   = 1'b1;
        pal_wr.addr = pidx_r;
        pal_wr.data = pcol_r;
        consume     = 1'b1;
      end else if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
        consume = 1'b1;
      end else if (!emit) begin
        // first or second byte of a BGR triple: hold it
        col_nxt   = col_cur;
        row_nxt   = row_cur;
        phase_nxt = phase_cur;
        consume   = 1'b1;
        if (triple_r == 2'd0) begin
          held_blue_nxt = byte_r;
          triple_nxt    = 2'd1;
        end else begin
          held_green_nxt = byte_r;
          triple_nxt     = 2'd2;
        end
      end else if (adv) begin
        desc.valid = 1'b1;
        phase_nxt  = phase_cur;
        row_nxt    = row_cur;
        col_nxt    = col_cur + XW'(1);
        if (row_end) begin
          col_nxt   = '0;
          row_nxt   = row_last ? '0 : row_cur + YW'(1);
          pad_nxt   = 2'd0 - phase_cur;
          phase_nxt = 2'd0;
        end
        if (cfg.depth == bpu_pkg::DEPTH_24BIT) begin
          triple_nxt = 2'd0;
        end
        if (last_pix) begin
          sub_nxt = 3'd0;
          consume = 1'b1;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
    end
  end

  assign in_ch.ready = !in_valid_r || consume;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      phase_r      <= 2'd0;
      pad_r        <= 2'd0;
      held_blue_r  <= 8'd0;
      held_green_r <= 8'd0;
      triple_r     <= 2'd0;
      sub_r        <= 3'd0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (consume) begin
        in_valid_r <= 1'b0;
      end
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      phase_r      <= phase_nxt;
      pad_r        <= pad_nxt;
      held_blue_r  <= held_blue_nxt;
      held_green_r <= held_green_nxt;
      triple_r     <= triple_nxt;
      sub_r        <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.mode;
      pidx_r <= in_ch.palette_index;
      pcol_r <= in_ch.palette_color;
      byte_r <= in_ch.data_byte;
    end
  end

endmodule

`default_nettype wire

/* src/bpu_palette_out.sv */
// Color table memory and output register: looks up palette pixels and
// holds each finished pixel until the receiver takes it.
// Depends on bpu_pkg and bpu_if.
`default_nettype none

module bpu_palette_out (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bpu_pkg::pal_wr_t    pal_wr,
  input  wire bpu_pkg::pix_desc_t  desc,
  output logic                     adv,
  bpu_out_if.source                out_ch
);

  logic [bpu_pkg::COLOR_W-1:0] mem [bpu_pkg::PAL_DEPTH];

  logic                         valid_r;
  logic [bpu_pkg::COLOR_W-1:0]  rd_r;
  logic [bpu_pkg::COLOR_W-1:0]  rgb_r;
  logic                         use_table_r;
  logic [bpu_pkg::COORD_W-1:0]  x_r;
  logic [bpu_pkg::COORD_W-1:0]  y_r;
  logic                         last_run_r;
  logic                         last_img_r;
  logic [bpu_pkg::COLOR_W-1:0]  color;

  // advance when the output register is empty or being drained
  assign adv = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      mem[pal_wr.addr] <= pal_wr.data;
    end
    if (adv) begin
      rd_r        <= mem[desc.addr];
      rgb_r       <= desc.rgb;
      use_table_r <= desc.use_table;
      x_r         <= desc.x;
      y_r         <= desc.y;
      last_run_r  <= desc.last_of_run;
      last_img_r  <= desc.last_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= desc.valid;
    end
  end

  assign color                = use_table_r ? rd_r : rgb_r;
  assign out_ch.valid         = valid_r;
  assign out_ch.red           = color[23:16];
  assign out_ch.green         = color[15:8];
  assign out_ch.blue          = color[7:0];
  assign out_ch.pixel_x       = x_r;
  assign out_ch.pixel_y       = y_r;
  assign out_ch.last_of_run   = last_run_r;
  assign out_ch.last_of_image = last_img_r;

endmodule

`default_nettype wire

/* src/bmp_pixel_unpacker.sv */
// Top level of the BMP pixel unpacker: configuration registers and the
// sequencer and output stage. Depends on bpu_pkg, bpu_if and submodules.
//
// in_ch carries one transaction per palette write (mode 0) or per byte of
// the uncompressed pixel-data area (mode 1). Load the palette first, then
// stream the bytes; row padding bytes are swallowed without output.
// out_ch carries one transaction per RGB pixel with its column and its
// flipped row; last_of_run marks the final pixel of a byte and
// last_of_image the final pixel of the image.
// cfg_we/cfg_index/cfg_wdata write depth, width and height; write them only
// while no byte is in flight. A pixel passes the input register and then
// the output register on its way to out_ch. Throughput: one byte per cycle
// for 8- and 24-bit data while out_ch does not stall; a 4-bit byte yields
// two pixels and a 1-bit byte up to eight, since the output register and
// the single color table read port handle one pixel per cycle. When out_ch
// stalls the output register holds its pixel and in_ch.ready drops
// once the input register holds a byte that must emit a pixel. Reset
// clears the position counters and the configuration to 24-bit, 1x1; the
// color table is not cleared and must be written before use.
`default_nettype none

module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bpu_in_if.sink                               in_ch,
  bpu_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpu_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  bpu_pkg::cfg_t      cfg_r;
  bpu_pkg::pal_wr_t   pal_wr;
  bpu_pkg::pix_desc_t desc;
  logic               adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth  <= bpu_pkg::DEPTH_24BIT;
      cfg_r.width  <= bpu_pkg::DIM_W'(1);
      cfg_r.height <= bpu_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bpu_pkg::CFG_IDX_DEPTH:  cfg_r.depth  <= bpu_pkg::depth_t'(cfg_wdata[1:0]);
        bpu_pkg::CFG_IDX_WIDTH:  cfg_r.width  <= cfg_wdata[bpu_pkg::DIM_W-1:0];
        bpu_pkg::CFG_IDX_HEIGHT: cfg_r.height <= cfg_wdata[bpu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  bpu_unpack #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_unpack (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .adv    (adv),
    .pal_wr (pal_wr),
    .desc   (desc)
  );

  bpu_palette_out u_palette_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .pal_wr (pal_wr),
    .desc   (desc),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
